// ----- rtl/core/tkbd_pkg.sv -----
// Package for the touch key baseline detector: item structs, register
// indexes, configuration group and sizing constants. No dependencies.
`timescale 1ns / 1ps

package tkbd_pkg;

    // Width of the raw oscillator count that is used; upper sample bits are dropped.
    localparam int SAMPLE_BITS      = 16;
    localparam int DATA_W           = 16;
    localparam int CAL_SAMPLES_DFLT = 20;
    localparam int CFG_IDX_W        = 3;

    // Register reset values
    localparam logic [DATA_W-1:0] DEADBAND_RST       = 16'd15;
    localparam logic [DATA_W-1:0] TOUCH_MARGIN_RST   = 16'd120;
    localparam logic [DATA_W-1:0] RELEASE_MARGIN_RST = 16'd10;
    localparam logic [DATA_W-1:0] HOLD_LIMIT_RST     = 16'd5000;
    localparam logic [DATA_W-1:0] RELEASE_CLEAR_RST  = 16'd100;
    localparam logic [DATA_W-1:0] RELEASE_RECAL_RST  = 16'd1000;
    localparam logic [DATA_W-1:0] FOCUS_COUNT_RST    = 16'd50;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEADBAND       = 3'd0,
        CFG_TOUCH_MARGIN   = 3'd1,
        CFG_RELEASE_MARGIN = 3'd2,
        CFG_HOLD_LIMIT     = 3'd3,
        CFG_RELEASE_CLEAR  = 3'd4,
        CFG_RELEASE_RECAL  = 3'd5,
        CFG_FOCUS_COUNT    = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic              sample_valid;
        logic [DATA_W-1:0] sample;
    } in_item_t;

    typedef struct packed {
        logic              key_out;
        logic              calibrating;
        logic [DATA_W-1:0] baseline;
        logic [DATA_W-1:0] filtered;
    } out_item_t;

    typedef struct packed {
        logic [DATA_W-1:0] deadband;
        logic [DATA_W-1:0] touch_margin;
        logic [DATA_W-1:0] release_margin;
        logic [DATA_W-1:0] hold_limit;
        logic [DATA_W-1:0] release_clear;
        logic [DATA_W-1:0] release_recal;
        logic [DATA_W-1:0] focus_count;
    } cfg_regs_t;

endpackage

// ----- rtl/core/touch_key_baseline_detector_core.sv -----
// Touch key baseline detector top level: handshakes, config registers,
// input and result registers around the tracking engine. Uses tkbd_pkg, tkbd_engine.
`timescale 1ns / 1ps
// Path: input register, then the combinational engine, then the result register.
// Throughput: 1 item per cycle while results are not stalled; all tracking state updates per step.
// Reset (rst_n, async, active low): state cleared, registers to defaults, pipeline empty.
// Config writes are always ready and take effect on the next processed item.

module touch_key_baseline_detector_core
    import tkbd_pkg::*;
#(
    parameter int CAL_SAMPLES = CAL_SAMPLES_DFLT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // input item channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_item,
    // result item channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_item,
    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    cfg_regs_t cfg_reg;
    in_item_t  in_item_reg;
    logic      in_valid_reg;
    out_item_t out_item_reg;
    logic      out_valid_reg;
    out_item_t engine_result;
    logic      res_free;
    logic      step;
    logic      in_take;

    // Result register takes a new item when empty or being drained this cycle.
    assign res_free = !out_valid_reg || !out_stall;
    // Advance the held input item through the engine into the result register.
    assign step     = in_valid_reg && res_free;
    // Input register is free when empty or advancing; a waiting result blocks it only
    // while it already holds an item.
    assign in_stall = in_valid_reg && !res_free;
    assign in_take  = in_valid && !in_stall;

    assign cfg_ready = 1'b1;

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.deadband       <= DEADBAND_RST;
            cfg_reg.touch_margin   <= TOUCH_MARGIN_RST;
            cfg_reg.release_margin <= RELEASE_MARGIN_RST;
            cfg_reg.hold_limit     <= HOLD_LIMIT_RST;
            cfg_reg.release_clear  <= RELEASE_CLEAR_RST;
            cfg_reg.release_recal  <= RELEASE_RECAL_RST;
            cfg_reg.focus_count    <= FOCUS_COUNT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DEADBAND:       cfg_reg.deadband       <= cfg_data;
                CFG_TOUCH_MARGIN:   cfg_reg.touch_margin   <= cfg_data;
                CFG_RELEASE_MARGIN: cfg_reg.release_margin <= cfg_data;
                CFG_HOLD_LIMIT:     cfg_reg.hold_limit     <= cfg_data;
                CFG_RELEASE_CLEAR:  cfg_reg.release_clear  <= cfg_data;
                CFG_RELEASE_RECAL:  cfg_reg.release_recal  <= cfg_data;
                CFG_FOCUS_COUNT:    cfg_reg.focus_count    <= cfg_data;
                default:            ;  // unmapped index: drop the write
            endcase
        end
    end

    // Input register: valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (step)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // Input register: payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg <= in_item;
        end
    end

    tkbd_engine #(
        .CAL_SAMPLES(CAL_SAMPLES)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_item_reg),
        .cfg    (cfg_reg),
        .result (engine_result)
    );

    // Result register: valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_free)
        begin
            out_valid_reg <= step;
        end
    end

    // Result register: payload, hold while stalled
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_item_reg <= engine_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ----- rtl/core/tkbd_engine.sv -----
// Tracking engine: calibration average, deadband filter, touch/release counters.
// Holds all tracking state. Depends on tkbd_pkg.
`timescale 1ns / 1ps

module tkbd_engine
    import tkbd_pkg::*;
#(
    parameter int CAL_SAMPLES = CAL_SAMPLES_DFLT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  in_item_t  item,
    input  cfg_regs_t cfg,
    output out_item_t result
);

    localparam int CNT_W     = $clog2(CAL_SAMPLES + 1);
    localparam int SUM_W     = DATA_W + CNT_W;
    localparam int CAL_SHIFT = SUM_W + $clog2(CAL_SAMPLES);
    localparam int RECIP_W   = CAL_SHIFT + 1;
    localparam logic [RECIP_W-1:0] CAL_RECIP =
        RECIP_W'(((64'd1 << CAL_SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));
    localparam logic [CNT_W-1:0] CAL_LAST = CNT_W'(CAL_SAMPLES);

    logic [CNT_W-1:0]  cal_count_reg,      cal_count_next;
    logic [SUM_W-1:0]  cal_sum_reg,        cal_sum_next;
    logic [DATA_W-1:0] held_reg,           held_next;
    logic [DATA_W-1:0] baseline_reg,       baseline_next;
    logic [DATA_W-1:0] filtered_reg,       filtered_next;
    logic [DATA_W-1:0] touch_count_reg,    touch_count_next;
    logic [DATA_W-1:0] release_count_reg,  release_count_next;
    logic              out_level_reg,      out_level_next;

    logic [DATA_W-1:0]          smp;
    logic [CNT_W-1:0]           cnt_inc;
    logic [SUM_W-1:0]           sum_inc;
    logic [SUM_W+RECIP_W-1:0]   cal_prod;
    logic signed [DATA_W+1:0]   held_s, filt_s, filt_new_s, base_s, diff_s, db_s;
    logic signed [DATA_W+1:0]   touch_thr_s, release_thr_s;
    logic [DATA_W:0]            touch_inc, release_inc;
    logic                       in_cal;

    assign smp      = DATA_W'(item.sample[SAMPLE_BITS-1:0]);
    assign in_cal   = (cal_count_reg < CAL_LAST);
    assign cnt_inc  = cal_count_reg + 1'b1;
    assign sum_inc  = cal_sum_reg + SUM_W'(smp);
    // exact truncated average: reciprocal multiply, valid for every sum below 2**SUM_W
    assign cal_prod = (SUM_W + RECIP_W)'(sum_inc) * (SUM_W + RECIP_W)'(CAL_RECIP);

    assign touch_inc   = {1'b0, touch_count_reg} + 1'b1;
    assign release_inc = {1'b0, release_count_reg} + 1'b1;

    always_comb
    begin
        cal_count_next     = cal_count_reg;
        cal_sum_next       = cal_sum_reg;
        held_next          = held_reg;
        baseline_next      = baseline_reg;
        filtered_next      = filtered_reg;
        touch_count_next   = touch_count_reg;
        release_count_next = release_count_reg;
        out_level_next     = out_level_reg;

        if (item.sample_valid)
        begin
            held_next = smp;
        end

        held_s        = $signed({2'b00, held_next});
        filt_s        = $signed({2'b00, filtered_reg});
        db_s          = $signed({2'b00, cfg.deadband});
        diff_s        = held_s - filt_s;
        filt_new_s    = filt_s;
        base_s        = $signed({2'b00, baseline_reg});
        touch_thr_s   = base_s - $signed({2'b00, cfg.touch_margin});
        release_thr_s = base_s - $signed({2'b00, cfg.release_margin});

        if (in_cal)
        begin
            if (item.sample_valid)
            begin
                cal_sum_next   = sum_inc;
                cal_count_next = cnt_inc;
                if (cnt_inc == CAL_LAST)
                begin
                    baseline_next = cal_prod[CAL_SHIFT +: DATA_W];
                end
            end
        end
        else
        begin
            // deadband: follow the held sample only on a large enough move
            if ((diff_s > db_s) || (diff_s < -db_s))
            begin
                filtered_next = held_next;
            end
            filt_new_s = $signed({2'b00, filtered_next});

            if (filt_new_s < touch_thr_s)
            begin
                if (touch_inc > {1'b0, cfg.hold_limit})
                begin
                    touch_count_next = '0;
                    baseline_next    = filtered_next;
                end
                else
                begin
                    touch_count_next = touch_inc[DATA_W-1:0];
                    if (touch_inc[DATA_W-1:0] == cfg.focus_count)
                    begin
                        out_level_next = ~out_level_reg;
                    end
                end
            end
            else if (filt_new_s > release_thr_s)
            begin
                release_count_next = release_inc[DATA_W-1:0];
                if (release_inc > {1'b0, cfg.release_clear})
                begin
                    touch_count_next = '0;
                end
                if (release_inc > {1'b0, cfg.release_recal})
                begin
                    release_count_next = '0;
                    baseline_next      = filtered_next;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_count_reg     <= '0;
            cal_sum_reg       <= '0;
            held_reg          <= '0;
            baseline_reg      <= '0;
            filtered_reg      <= '0;
            touch_count_reg   <= '0;
            release_count_reg <= '0;
            out_level_reg     <= 1'b0;
        end
        else if (step)
        begin
            cal_count_reg     <= cal_count_next;
            cal_sum_reg       <= cal_sum_next;
            held_reg          <= held_next;
            baseline_reg      <= baseline_next;
            filtered_reg      <= filtered_next;
            touch_count_reg   <= touch_count_next;
            release_count_reg <= release_count_next;
            out_level_reg     <= out_level_next;
        end
    end

    assign result.key_out     = out_level_next;
    assign result.calibrating = (cal_count_next < CAL_LAST);
    assign result.baseline    = baseline_next;
    assign result.filtered    = filtered_next;

endmodule

// ----- rtl/core/tkbd_checker.sv -----
// Port-level checker for the touch key baseline detector, bound to the top level.
// Depends on tkbd_pkg and touch_key_baseline_detector_core.
`timescale 1ns / 1ps

module tkbd_checker
    import tkbd_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_item
);

    logic cal_done_reg;

    // Track whether any delivered item has shown calibration finished.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_done_reg <= 1'b0;
        end
        else if (out_valid && !out_stall && !out_item.calibrating)
        begin
            cal_done_reg <= 1'b1;
        end
    end

    // A stalled item holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("stalled result item changed");

    // Calibration never restarts once finished.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cal_done_reg |-> !out_item.calibrating)
        else $error("calibration flag came back after finishing");

    // No tracking activity while calibrating.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.calibrating |-> !out_item.key_out && (out_item.filtered == '0))
        else $error("key output or filter moved during calibration");

    // An empty result stage never stalls the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with no result waiting");

endmodule

bind touch_key_baseline_detector_core tkbd_checker u_tkbd_checker (.*);

// ----- sim/touch_key_baseline_detector_core_tb.sv -----
// Self-checking testbench for touch_key_baseline_detector_core: calibration, deadband,
// touch/release counting, re-baselining and key toggling under random flow control.
// Depends on tkbd_pkg and the core RTL only.
`timescale 1ns / 1ps

module touch_key_baseline_detector_core_tb;
    import tkbd_pkg::*;

    localparam int CAL_N = CAL_SAMPLES_DFLT;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    in_item_t             in_item   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_item_t            out_item;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0]    cfg_data  = '0;

    touch_key_baseline_detector_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Samples waiting to be offered, and readings the block still owes us.
    in_item_t  sample_queue[$];
    out_item_t expected_readings[$];
    int        error_count = 0;
    int        phase_idx   = -1;

    // Shadow copy of the register file, updated on each accepted write.
    cfg_regs_t regs = '{DEADBAND_RST, TOUCH_MARGIN_RST, RELEASE_MARGIN_RST,
                        HOLD_LIMIT_RST, RELEASE_CLEAR_RST, RELEASE_RECAL_RST,
                        FOCUS_COUNT_RST};

    // Predicted tracking state
    logic [4:0]        cal_cnt   = '0;
    logic [20:0]       cal_acc   = '0;
    logic [DATA_W-1:0] held_smp  = '0;
    logic [DATA_W-1:0] base_lvl  = '0;
    logic [DATA_W-1:0] filt_lvl  = '0;
    logic [DATA_W-1:0] touch_cnt = '0;
    logic [DATA_W-1:0] rel_cnt   = '0;
    logic              key_lvl   = 1'b0;

    // Flow control helpers
    int   hold_left  = 0;
    logic hold_fired = 1'b0;
    logic calm;

    // Phase 2 runs with no idling on either side.
    assign calm = (phase_idx == 2);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Advance the tracker by one pass and queue the reading it produces.
    task automatic track_touch_pass(input in_item_t it);
        int          held;
        int          filt;
        int          base;
        int          diff;
        int          db;
        int unsigned nxt;
        out_item_t   reading;
        if (cal_cnt < CAL_N)
        begin
            // Gather the initial average; passes without a sample change nothing.
            if (it.sample_valid)
            begin
                held_smp = it.sample;
                cal_acc  = cal_acc + it.sample;
                cal_cnt  = cal_cnt + 1'b1;
                if (cal_cnt >= CAL_N)
                    base_lvl = DATA_W'(cal_acc / CAL_N);
            end
        end
        else
        begin
            if (it.sample_valid)
                held_smp = it.sample;
            held = int'(held_smp);
            filt = int'(filt_lvl);
            db   = int'(regs.deadband);
            diff = held - filt;
            // Follow the held sample only when it leaves the deadband.
            if (diff > db || diff < -db)
                filt_lvl = held_smp;
            filt = int'(filt_lvl);
            base = int'(base_lvl);
            if (filt < base - int'(regs.touch_margin))
            begin
                nxt = touch_cnt + 32'd1;
                if (nxt > regs.hold_limit)
                begin
                    touch_cnt = '0;
                    base_lvl  = filt_lvl;
                end
                else
                begin
                    touch_cnt = nxt[DATA_W-1:0];
                    if (touch_cnt == regs.focus_count)
                        key_lvl = ~key_lvl;
                end
            end
            else if (filt > base - int'(regs.release_margin))
            begin
                nxt     = rel_cnt + 32'd1;
                rel_cnt = nxt[DATA_W-1:0];
                if (nxt > regs.release_clear)
                    touch_cnt = '0;
                if (nxt > regs.release_recal)
                begin
                    rel_cnt  = '0;
                    base_lvl = filt_lvl;
                end
            end
        end
        reading.key_out     = key_lvl;
        reading.calibrating = (cal_cnt < CAL_N);
        reading.baseline    = base_lvl;
        reading.filtered    = filt_lvl;
        expected_readings.push_back(reading);
    endtask

    // Write one register through the config channel and mirror it.
    task automatic write_reg(input cfg_idx_t idx, input logic [DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_DEADBAND:       regs.deadband       = val;
            CFG_TOUCH_MARGIN:   regs.touch_margin   = val;
            CFG_RELEASE_MARGIN: regs.release_margin = val;
            CFG_HOLD_LIMIT:     regs.hold_limit     = val;
            CFG_RELEASE_CLEAR:  regs.release_clear  = val;
            CFG_RELEASE_RECAL:  regs.release_recal  = val;
            CFG_FOCUS_COUNT:    regs.focus_count    = val;
            default:            ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    // Hold until every queued sample went in and every reading came back.
    task automatic wait_drained();
        while (sample_queue.size() != 0 || in_valid || expected_readings.size() != 0)
            @(posedge clk);
        // Pipeline is two deep; let it settle before touching registers.
        repeat (4) @(posedge clk);
    endtask

    // Queue bursts of samples aimed at the touch zone, the rest level, the gap
    // between zones, or pure noise. Each burst is aimed at the baseline the
    // tracker holds once the previous burst has been offered.
    task automatic feed_random(input int n);
        int       made;
        int       kind;
        int       len;
        int       lvl;
        int       val;
        int       k;
        logic     noisy;
        in_item_t it;
        made = 0;
        while (made < n)
        begin
            while (sample_queue.size() != 0)
                @(posedge clk);
            kind  = int'($urandom_range(0, 99));
            len   = int'($urandom_range(2, 40));
            noisy = (kind >= 80);
            if (kind < 35)
                lvl = int'(base_lvl) - int'(regs.touch_margin) - int'($urandom_range(1, 400));
            else if (kind < 70)
                lvl = int'(base_lvl) + int'($urandom_range(0, 60)) - 30;
            else
                lvl = int'(base_lvl)
                      - (int'(regs.touch_margin) + int'(regs.release_margin)) / 2;
            for (k = 0; k < len; k++)
            begin
                it.sample_valid = ($urandom_range(0, 9) != 0);
                if (noisy)
                    it.sample = DATA_W'($urandom);
                else
                begin
                    val = lvl + int'($urandom_range(0, 12)) - 6;
                    if (val < 0)
                        val = 0;
                    if (val > 65535)
                        val = 65535;
                    it.sample = DATA_W'(val);
                end
                sample_queue.push_back(it);
                made++;
            end
        end
    endtask

    // Driver: advance to the next sample only when the current one is taken
    // or none is offered; idle at random outside the calm phase.
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || !in_stall)
        begin
            if (sample_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 22))
            begin
                in_item  <= sample_queue.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Predict on every accepted input item.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            track_touch_pass(in_item);
    end

    // Long receiver hold-off, once, early in the first random phase while
    // the sender keeps offering: the block must fill up and stall its input.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_left  <= 0;
            hold_fired <= 1'b0;
        end
        else if (!hold_fired && phase_idx == 0 && in_valid)
        begin
            hold_left  <= 200;
            hold_fired <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Receiver stall
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= (hold_left != 0) || (!calm && $urandom_range(0, 99) < 22);
    end

    // Monitor: check each accepted reading against the oldest prediction.
    always @(posedge clk)
    begin : check_readings
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_readings.size() == 0)
            begin
                if (error_count < 10)
                    $display("ERROR: unexpected reading %p", out_item);
                error_count++;
            end
            else
            begin
                want = expected_readings.pop_front();
                if (out_item.key_out !== want.key_out
                    || out_item.calibrating !== want.calibrating
                    || out_item.baseline !== want.baseline
                    || out_item.filtered !== want.filtered)
                begin
                    if (error_count < 10)
                        $display("ERROR: key_out %0b/%0b calibrating %0b/%0b baseline %0d/%0d filtered %0d/%0d (exp/act)",
                                 want.key_out, out_item.key_out,
                                 want.calibrating, out_item.calibrating,
                                 want.baseline, out_item.baseline,
                                 want.filtered, out_item.filtered);
                    error_count++;
                end
            end
        end
    end

    // Stimulus and phase control
    initial
    begin : run_phases
        cfg_regs_t plan;
        in_item_t  it;
        int        k;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Calibration: an empty pass first, then full-scale and zero samples
        // alternating so the average lands mid-range.
        it = '{sample_valid: 1'b0, sample: 16'hFFFF};
        sample_queue.push_back(it);
        for (k = 0; k < CAL_N; k++)
        begin
            it = '{sample_valid: 1'b1, sample: (k % 2 == 0) ? 16'hFFFF : 16'h0000};
            sample_queue.push_back(it);
        end
        // Tracking: deep touch, full release, a pass reusing the held sample,
        // then a value between the two zones.
        it = '{sample_valid: 1'b1, sample: 16'h0000};
        sample_queue.push_back(it);
        it = '{sample_valid: 1'b1, sample: 16'hFFFF};
        sample_queue.push_back(it);
        it = '{sample_valid: 1'b0, sample: 16'h1234};
        sample_queue.push_back(it);
        it = '{sample_valid: 1'b1, sample: 16'd32700};
        sample_queue.push_back(it);
        wait_drained();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                // short counts so toggles and re-baselines happen often
                0: plan = '{16'd4, 16'd200, 16'd50, 16'd30, 16'd5, 16'd20, 16'd8};
                // lowest legal values
                1: plan = '{16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'd1, 16'd1};
                // highest values
                3: plan = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                            16'hFFFF, 16'hFFFF};
                5: plan = '{DEADBAND_RST, TOUCH_MARGIN_RST, RELEASE_MARGIN_RST,
                            HOLD_LIMIT_RST, RELEASE_CLEAR_RST, RELEASE_RECAL_RST,
                            FOCUS_COUNT_RST};
                default:
                begin
                    plan.deadband       = DATA_W'($urandom_range(0, 40));
                    plan.touch_margin   = DATA_W'($urandom_range(0, 800));
                    plan.release_margin = DATA_W'($urandom_range(0, 800));
                    plan.hold_limit     = DATA_W'($urandom_range(1, 80));
                    plan.release_clear  = DATA_W'($urandom_range(0, 30));
                    plan.release_recal  = DATA_W'($urandom_range(1, 120));
                    plan.focus_count    = DATA_W'($urandom_range(1, 25));
                end
            endcase
            write_reg(CFG_DEADBAND,       plan.deadband);
            write_reg(CFG_TOUCH_MARGIN,   plan.touch_margin);
            write_reg(CFG_RELEASE_MARGIN, plan.release_margin);
            write_reg(CFG_HOLD_LIMIT,     plan.hold_limit);
            write_reg(CFG_RELEASE_CLEAR,  plan.release_clear);
            write_reg(CFG_RELEASE_RECAL,  plan.release_recal);
            write_reg(CFG_FOCUS_COUNT,    plan.focus_count);
            phase_idx = ph;
            feed_random(165);
            wait_drained();
        end

        repeat (8) @(posedge clk);
        if (expected_readings.size() != 0)
            error_count++;
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
